@@ sv/reload_down_timer_unit_assert.svh @@
// Assertion macros used by the timer core (rdt_core).
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef RELOAD_DOWN_TIMER_UNIT_ASSERT_SVH
`define RELOAD_DOWN_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rdt_pkg.sv @@
// Shared types and constants for the reload down timer.
// No dependencies; used by every RTL file of the block.
package rdt_pkg;

  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CTRL_W      = 4;
  localparam int unsigned OFFSET_BITS = 12;

  localparam logic [LEN_W-1:0] ACCESS_BYTES = 4'd4;

  // Control register bits
  localparam int unsigned CTL_ENABLE  = 0;
  localparam int unsigned CTL_EXT_EN  = 1;
  localparam int unsigned CTL_EXT_CLK = 2;
  localparam int unsigned CTL_INT_EN  = 3;

  // Register byte offsets
  localparam logic [ADDR_W-1:0] ADDR_CTRL   = 12'h000;
  localparam logic [ADDR_W-1:0] ADDR_COUNT  = 12'h004;
  localparam logic [ADDR_W-1:0] ADDR_RELOAD = 12'h008;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 12'h00C;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } rdt_op_e;

  typedef enum logic [1:0] {
    RESP_OK      = 2'd0,
    RESP_GENERIC = 2'd1,
    RESP_BURST   = 2'd2,
    RESP_ADDRESS = 2'd3
  } rdt_resp_e;

  typedef struct packed {
    rdt_op_e           opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [LEN_W-1:0]  access_length;
    logic              byte_enables_given;
    logic [LEN_W-1:0]  streaming_width;
    logic              ext_level;
  } rdt_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    rdt_resp_e         response;
    logic              irq;
  } rdt_result_t;

endpackage

@@ sv/rdt_in_stage.sv @@
// Input register of the timer: holds one accepted beat until the core takes it.
// Depends on rdt_pkg.
module rdt_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rdt_pkg::rdt_item_t item_i,
  output logic              valid_o,
  input  logic              advance_i,
  output rdt_pkg::rdt_item_t item_o
);

  logic               valid_q;
  rdt_pkg::rdt_item_t item_q;

  // The slot frees in the same cycle the core consumes it.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ sv/rdt_core.sv @@
// Timer registers, bus access checks and tick counting for one beat.
// Depends on rdt_pkg and reload_down_timer_unit_assert.svh.
`include "reload_down_timer_unit_assert.svh"

module rdt_core #(
  parameter int unsigned OFFSET_BITS = rdt_pkg::OFFSET_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  rdt_pkg::rdt_item_t  item_i,
  output rdt_pkg::rdt_result_t res_o
);

  localparam int unsigned AW = rdt_pkg::ADDR_W;
  localparam logic [AW-1:0] AddrMask = (OFFSET_BITS >= AW) ? {AW{1'b1}} :
                                       AW'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [rdt_pkg::CTRL_W-1:0] ctrl_q, ctrl_d;
  logic [rdt_pkg::DATA_W-1:0] count_q, count_d;
  logic [rdt_pkg::DATA_W-1:0] reload_q, reload_d;
  logic                       status_q, status_d;
  logic                       irq_q, irq_d;
  logic                       prev_q, prev_d;

  logic [AW-1:0] adr;
  logic          rising;
  logic          counts;

  assign adr = item_i.address & AddrMask;

  always_comb begin
    ctrl_d          = ctrl_q;
    count_d         = count_q;
    reload_d        = reload_q;
    status_d        = status_q;
    irq_d           = irq_q;
    prev_d          = prev_q;
    res_o.read_data = '0;
    res_o.response  = rdt_pkg::RESP_OK;
    rising          = item_i.ext_level && !prev_q;
    counts          = ctrl_q[rdt_pkg::CTL_ENABLE]
                      && (!ctrl_q[rdt_pkg::CTL_EXT_CLK] || rising)
                      && (!ctrl_q[rdt_pkg::CTL_EXT_EN] || item_i.ext_level);
    unique case (item_i.opcode)
      rdt_pkg::OP_TICK: begin
        prev_d = item_i.ext_level;
        if (counts) begin
          if (count_q == '0) begin
            count_d  = reload_q;
            status_d = 1'b1;
            if (ctrl_q[rdt_pkg::CTL_INT_EN]) begin
              irq_d = 1'b1;
            end
          end else begin
            count_d = count_q - {{(rdt_pkg::DATA_W-1){1'b0}}, 1'b1};
          end
        end
      end
      rdt_pkg::OP_READ, rdt_pkg::OP_WRITE: begin
        priority if (item_i.access_length != rdt_pkg::ACCESS_BYTES) begin
          res_o.response = rdt_pkg::RESP_GENERIC;
        end else if (item_i.byte_enables_given
                     || (item_i.streaming_width < rdt_pkg::ACCESS_BYTES)) begin
          res_o.response = rdt_pkg::RESP_BURST;
        end else begin
          unique case (adr)
            rdt_pkg::ADDR_CTRL: begin
              if (item_i.opcode == rdt_pkg::OP_READ) begin
                res_o.read_data = {{(rdt_pkg::DATA_W-rdt_pkg::CTRL_W){1'b0}}, ctrl_q};
              end else begin
                ctrl_d = item_i.write_data[rdt_pkg::CTRL_W-1:0];
              end
            end
            rdt_pkg::ADDR_COUNT: begin
              if (item_i.opcode == rdt_pkg::OP_READ) begin
                res_o.read_data = count_q;
              end else begin
                count_d = item_i.write_data;
              end
            end
            rdt_pkg::ADDR_RELOAD: begin
              if (item_i.opcode == rdt_pkg::OP_READ) begin
                res_o.read_data = reload_q;
              end else begin
                reload_d = item_i.write_data;
                count_d  = item_i.write_data;
              end
            end
            rdt_pkg::ADDR_STATUS: begin
              if (item_i.opcode == rdt_pkg::OP_READ) begin
                res_o.read_data = {{(rdt_pkg::DATA_W-1){1'b0}}, status_q};
              end else if (item_i.write_data[0]) begin
                status_d = 1'b0;
                irq_d    = 1'b0;
              end
            end
            default: begin
              res_o.response = rdt_pkg::RESP_ADDRESS;
            end
          endcase
        end
      end
      default: begin
        // unused opcode: no state change
      end
    endcase
    res_o.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      count_q  <= '0;
      reload_q <= '0;
      status_q <= 1'b0;
      irq_q    <= 1'b0;
      prev_q   <= 1'b0;
    end else if (fire_i) begin
      ctrl_q   <= ctrl_d;
      count_q  <= count_d;
      reload_q <= reload_d;
      status_q <= status_d;
      irq_q    <= irq_d;
      prev_q   <= prev_d;
    end
  end

  `RDT_ASSERT_NOW(a_irq_needs_status, irq_q, status_q, "irq raised without status flag")
  `RDT_ASSERT_NEXT(a_count_holds, !fire_i, $stable(count_q), "counter moved without a beat")
  `RDT_ASSERT_NOW(a_tick_result, fire_i && (item_i.opcode == rdt_pkg::OP_TICK),
                  (res_o.response == rdt_pkg::RESP_OK) && (res_o.read_data == '0),
                  "tick produced a bus response")
  `RDT_ASSERT_NEXT(a_failed_access_holds, fire_i && (res_o.response != rdt_pkg::RESP_OK),
                   $stable(ctrl_q) && $stable(reload_q) && $stable(count_q),
                   "failed access changed timer state")

endmodule

@@ sv/rdt_out_stage.sv @@
// Result register of the timer: holds one result beat until the sink takes it.
// Depends on rdt_pkg.
module rdt_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rdt_pkg::rdt_result_t res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output rdt_pkg::rdt_result_t res_o
);

  logic                 valid_q;
  rdt_pkg::rdt_result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ sv/reload_down_timer_unit.sv @@
// Top level of the reload down timer: input register, core, result register.
// Depends on rdt_pkg, rdt_in_stage, rdt_core and rdt_out_stage.
//
//   channel  | dir | tdata                                  | tuser
//   s_axis   | in  | address, write_data, length, be, sw, ext | opcode
//   m_axis   | out | read_data, response, irq               | -
//
// Every beat yields one result beat, held first in the input register and then in the result register.
// One beat is accepted per cycle while the sink keeps taking results, and timer
// state updates as the beat moves into the result register.
// Reset clears all timer registers and both stage valid flags.
// A stalled sink holds the result register; the input register fills behind it
// and then drops tready until the result beat leaves.
module reload_down_timer_unit #(
  parameter int unsigned OFFSET_BITS = rdt_pkg::OFFSET_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] address, [43:12] write_data, [47:44] access_length,
  // [48] byte_enables_given, [52:49] streaming_width, [53] ext_level
  input  logic [55:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data, [33:32] response, [34] irq
  output logic [39:0] m_axis_tdata
);

  rdt_pkg::rdt_item_t   in_item;
  rdt_pkg::rdt_item_t   stage_item;
  rdt_pkg::rdt_result_t core_res;
  rdt_pkg::rdt_result_t out_res;
  logic                 stage_valid;
  logic                 out_free;
  logic                 fire;

  always_comb begin
    in_item.opcode             = rdt_pkg::rdt_op_e'(s_axis_tuser);
    in_item.address            = s_axis_tdata[11:0];
    in_item.write_data         = s_axis_tdata[43:12];
    in_item.access_length      = s_axis_tdata[47:44];
    in_item.byte_enables_given = s_axis_tdata[48];
    in_item.streaming_width    = s_axis_tdata[52:49];
    in_item.ext_level          = s_axis_tdata[53];
  end

  // Advance the held beat whenever the result register can take it.
  assign fire = stage_valid && out_free;

  rdt_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (stage_valid),
    .advance_i (fire),
    .item_o    (stage_item)
  );

  rdt_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stage_item),
    .res_o  (core_res)
  );

  rdt_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.irq, out_res.response, out_res.read_data};

endmodule
